>>> rtl/mabsg_pkg.sv
package mabsg_pkg;

	localparam int AXES = 6;
	localparam int STEP_W = 31;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam logic [15:0] MIN_PERIOD_RST = 16'd1;

	typedef struct packed {
		logic        mode;
		logic [30:0] axis_steps_0;
		logic [30:0] axis_steps_1;
		logic [30:0] axis_steps_2;
		logic [30:0] axis_steps_3;
		logic [30:0] axis_steps_4;
		logic [30:0] axis_steps_5;
		logic [30:0] block_events;
		logic [15:0] seg_ticks;
		logic [15:0] seg_period;
		logic [7:0]  block_id;
		logic [5:0]  dir_bits;
	} item_t;

	typedef struct packed {
		logic        accepted;
		logic [5:0]  step_bits;
		logic [5:0]  dir_out;
		logic [15:0] period_out;
		logic        period_load;
		logic        new_block;
		logic [7:0]  done_block_id;
		logic        run_end;
	} result_t;

	typedef struct packed {
		logic [AXES-1:0][STEP_W-1:0] steps;
		logic [STEP_W-1:0]           events;
		logic [15:0]                 ticks;
		logic [15:0]                 period;
		logic [7:0]                  block_id;
		logic [5:0]                  dirs;
	} seg_t;

	typedef struct packed {
		logic is_tick;
		logic zero_ticks;
		seg_t seg;
	} cmd_t;

endpackage

>>> rtl/mabsg_chan_if.sv
interface mabsg_chan_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/mabsg_ram.sv
module mabsg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/mabsg_front.sv
module mabsg_front (
	input  logic         clk,
	input  logic         arst_n,
	mabsg_chan_if.sink   item,
	mabsg_chan_if.source cmd
);

	mabsg_pkg::cmd_t cmd_d;
	mabsg_pkg::cmd_t fifo_q [2];
	logic            wr_q;
	logic            rd_q;
	logic [1:0]      cnt_q;
	logic            push;
	logic            pop;

	// classify the item and gather the segment fields
	always_comb begin
		cmd_d.is_tick         = item.data.mode;
		cmd_d.zero_ticks      = (item.data.seg_ticks == 16'd0);
		cmd_d.seg.steps[0]    = item.data.axis_steps_0;
		cmd_d.seg.steps[1]    = item.data.axis_steps_1;
		cmd_d.seg.steps[2]    = item.data.axis_steps_2;
		cmd_d.seg.steps[3]    = item.data.axis_steps_3;
		cmd_d.seg.steps[4]    = item.data.axis_steps_4;
		cmd_d.seg.steps[5]    = item.data.axis_steps_5;
		cmd_d.seg.events      = item.data.block_events;
		cmd_d.seg.ticks       = item.data.seg_ticks;
		cmd_d.seg.period      = item.data.seg_period;
		cmd_d.seg.block_id    = item.data.block_id;
		cmd_d.seg.dirs        = item.data.dir_bits;
	end

	assign item.ready = (cnt_q != 2'd2);
	assign push       = item.valid && item.ready;
	assign cmd.valid  = (cnt_q != 2'd0);
	assign cmd.data   = fifo_q[rd_q];
	assign pop        = cmd.valid && cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= cmd_d;
		end
	end

endmodule

>>> rtl/mabsg_back.sv
module mabsg_back #(
	parameter int QUEUE_DEPTH = mabsg_pkg::QUEUE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	mabsg_chan_if.sink   cmd,
	mabsg_chan_if.sink   cfg,
	mabsg_chan_if.source rsp
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int SEG_W = $bits(mabsg_pkg::seg_t);
	localparam int AX = mabsg_pkg::AXES;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	logic [15:0]        min_q;
	logic [PTR_W-1:0]   head_q;
	logic [PTR_W-1:0]   tail_q;
	logic [PTR_W-1:0]   head_d;
	logic [CNT_W-1:0]   count_q;
	logic [31:0]        counter_q [AX];
	logic [31:0]        cnt_next [AX];
	logic [15:0]        ticks_left_q;
	logic               seg_active_q;
	logic [7:0]         active_block_q;
	logic               block_valid_q;
	logic [5:0]         active_dirs_q;
	logic               byp_hit_q;
	mabsg_pkg::seg_t    byp_data_q;
	logic [SEG_W-1:0]   ram_rdata;
	mabsg_pkg::seg_t    head_seg;
	logic               res_valid_q;
	mabsg_pkg::result_t res_data_q;
	mabsg_pkg::result_t res_d;
	logic               out_free;
	logic               exe;
	logic               load_ok;
	logic               tick;
	logic               run_end;
	logic               work;
	logic               newblk;
	logic               pop;
	logic [15:0]        ticks_cur;
	logic [15:0]        ticks_dec;
	logic [AX-1:0]      hit;
	logic [31:0]        ev;
	logic [31:0]        base;
	logic [31:0]        sum;

	assign out_free  = !res_valid_q || rsp.ready;
	assign cmd.ready = out_free;
	assign cfg.ready = 1'b1;
	assign rsp.valid = res_valid_q;
	assign rsp.data  = res_data_q;

	always_comb begin
		head_seg  = byp_hit_q ? byp_data_q : mabsg_pkg::seg_t'(ram_rdata);
		exe       = cmd.valid && out_free;
		load_ok   = exe && !cmd.data.is_tick && !cmd.data.zero_ticks
			&& (count_q != CNT_W'(QUEUE_DEPTH));
		tick      = exe && cmd.data.is_tick;
		run_end   = tick && !seg_active_q && (count_q == '0);
		work      = tick && !run_end;
		newblk    = work && !seg_active_q
			&& (!block_valid_q || (head_seg.block_id != active_block_q));
		ticks_cur = seg_active_q ? ticks_left_q : head_seg.ticks;
		ticks_dec = ticks_cur - 16'd1;
		pop       = work && (ticks_dec == 16'd0);
		ev        = {1'b0, head_seg.events};
		for (int a = 0; a < AX; a++) begin
			base        = newblk ? ev : counter_q[a];
			sum         = base + {1'b0, head_seg.steps[a]};
			hit[a]      = work && (sum > ev);
			cnt_next[a] = hit[a] ? sum - ev : sum;
		end
		head_d = pop ? ptr_inc(head_q) : head_q;

		res_d = '0;
		if (!cmd.data.is_tick) begin
			res_d.accepted = load_ok;
		end else begin
			res_d.step_bits     = hit;
			res_d.dir_out       = newblk ? head_seg.dirs : active_dirs_q;
			res_d.done_block_id = active_block_q;
			res_d.run_end       = run_end;
			if (work) begin
				res_d.period_out  = (head_seg.period < min_q) ? min_q : head_seg.period;
				res_d.period_load = !seg_active_q;
				res_d.new_block   = newblk;
			end
		end
	end

	mabsg_ram #(
		.WIDTH(SEG_W),
		.DEPTH(QUEUE_DEPTH)
	) u_seg_ram (
		.clk  (clk),
		.we   (load_ok),
		.waddr(tail_q),
		.wdata(cmd.data.seg),
		.raddr(head_d),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q          <= mabsg_pkg::MIN_PERIOD_RST;
			head_q         <= '0;
			tail_q         <= '0;
			count_q        <= '0;
			ticks_left_q   <= '0;
			seg_active_q   <= 1'b0;
			active_block_q <= '0;
			block_valid_q  <= 1'b0;
			active_dirs_q  <= '0;
			byp_hit_q      <= 1'b0;
			res_valid_q    <= 1'b0;
			for (int a = 0; a < AX; a++) begin
				counter_q[a] <= '0;
			end
		end else begin
			if (cfg.valid) begin
				min_q <= cfg.data;
			end
			byp_hit_q <= load_ok && (tail_q == head_d);
			head_q    <= head_d;
			if (load_ok) begin
				tail_q  <= ptr_inc(tail_q);
				count_q <= count_q + CNT_W'(1);
			end else if (pop) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (work) begin
				ticks_left_q <= ticks_dec;
				seg_active_q <= !pop;
				for (int a = 0; a < AX; a++) begin
					counter_q[a] <= cnt_next[a];
				end
			end
			if (newblk) begin
				block_valid_q  <= 1'b1;
				active_block_q <= head_seg.block_id;
				active_dirs_q  <= head_seg.dirs;
			end
			if (out_free) begin
				res_valid_q <= exe;
			end
		end
	end

	always_ff @(posedge clk) begin
		byp_data_q <= cmd.data.seg;
		if (exe) begin
			res_data_q <= res_d;
		end
	end

	// an open segment always sits in the queue
	assert property (@(posedge clk) disable iff (!arst_n)
		seg_active_q |-> (count_q != '0))
		else $error("active segment with empty queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (head_q == tail_q))
		else $error("empty queue with head and tail apart");

	assert property (@(posedge clk) disable iff (!arst_n)
		load_ok |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("stored segment not counted");

	assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (!seg_active_q && (head_q != $past(head_q))))
		else $error("segment end did not advance the head");

	assert property (@(posedge clk) disable iff (!arst_n)
		run_end |-> (hit == '0 && !newblk))
		else $error("run end with step or block start");

endmodule

>>> rtl/multi_axis_bresenham_step_generator_top.sv
// channel  dir  payload               accepted when
// cmd      in   mabsg_pkg::item_t     cmd.valid && cmd.ready
// rsp      out  mabsg_pkg::result_t   rsp.valid && rsp.ready
// cfg      in   min_step_period[15:0] cfg.valid && cfg.ready (always ready)
//
// one item per cycle sustained while rsp is ready; a result is registered in the front
// queue and then the back output register, and leaves at the next edge at the earliest
// per-axis counters are registered straight from their combinational sums
// reset: all control state cleared at once, no clearing pass, segment ram not cleared
// a stalled rsp fills the two-entry front queue before cmd.ready drops
module multi_axis_bresenham_step_generator_top #(
	parameter int QUEUE_DEPTH = mabsg_pkg::QUEUE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	mabsg_chan_if.sink   cmd,
	mabsg_chan_if.sink   cfg,
	mabsg_chan_if.source rsp
);

	mabsg_chan_if #(.T(mabsg_pkg::cmd_t)) cmd_q ();

	mabsg_front u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (cmd),
		.cmd   (cmd_q.source)
	);

	mabsg_back #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_q.sink),
		.cfg   (cfg),
		.rsp   (rsp)
	);

endmodule
